[sv/ubx_rx_pkg.sv]
// Shared constants, command types and field widths for the UBX frame receiver.
`default_nettype none
package ubx_rx_pkg;

   // Frame buffer geometry.
   localparam int BUF_BYTES      = 512;
   localparam int FRAME_OVERHEAD = 8;
   localparam int ADDR_W         = $clog2(BUF_BYTES);
   localparam int FILL_W         = $clog2(BUF_BYTES + 1);
   localparam int MAX_LEN        = BUF_BYTES - FRAME_OVERHEAD;
   localparam int LEN_W          = $clog2(MAX_LEN + 1);

   // Fixed item field widths.
   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 9;
   localparam int STATUS_W = 3;
   localparam int PLEN_W   = 9;

   // Sync bytes.
   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_RX   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DROP = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_BUSY         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_CK       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REFUSED      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DROPPED      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DROP_REFUSED = 3'd6;
   localparam logic [STATUS_W-1:0] ST_READ         = 3'd7;

   // Command queue geometry.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      K_NOP,
      K_RX,
      K_DROP,
      K_READ
   } kind_type;

   // One classified command as it sits in the queue.
   typedef struct packed {
      kind_type            kind;
      logic                sync1_hit;
      logic                sync2_hit;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  read_index;
   } cmd_type;

   // Head of the queue as seen by the execution side.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage
`default_nettype wire

[sv/ubx_rx_if.sv]
// Handshake interfaces for the request and response channels.
`default_nettype none
interface ubx_req_if import ubx_rx_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   rx_byte;
   logic [INDEX_W-1:0]  read_index;

   modport source (output valid, output opcode, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input opcode, input rx_byte, input read_index,
                   output ready);
endinterface

interface ubx_rsp_if import ubx_rx_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   msg_class;
   logic [BYTE_W-1:0]   msg_id;
   logic [PLEN_W-1:0]   payload_length;
   logic [BYTE_W-1:0]   read_data;

   modport source (output valid, output status, output msg_class, output msg_id,
                   output payload_length, output read_data, input ready);
   modport sink   (input valid, input status, input msg_class, input msg_id,
                   input payload_length, input read_data, output ready);
endinterface
`default_nettype wire

[sv/ubx_rx_front.sv]
// Request intake: classifies each item and queues it for the execution side.
`default_nettype none
module ubx_rx_front import ubx_rx_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ubx_req_if.sink    req_ch,
   output q_head_type head,
   input  wire logic  pop
);

   cmd_type              ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   cmd_type              cmd_new;
   logic                 push;

   assign req_ch.ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   // Classify the incoming item.
   always_comb begin
      cmd_new.rx_byte    = req_ch.rx_byte;
      cmd_new.read_index = req_ch.read_index;
      cmd_new.sync1_hit  = (req_ch.rx_byte == SYNC_FIRST);
      cmd_new.sync2_hit  = (req_ch.rx_byte == SYNC_SECOND);
      case (req_ch.opcode)
         OP_RX:   cmd_new.kind = K_RX;
         OP_DROP: cmd_new.kind = K_DROP;
         OP_READ: cmd_new.kind = K_READ;
         default: cmd_new.kind = K_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = ent_ff[rd_ptr_ff];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("command queue count exceeds its depth");

   a_count_push : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count did not advance on a push");

endmodule
`default_nettype wire

[sv/ubx_rx_back.sv]
// Frame parser execution: phase tracking, checksum, frame buffer and result register.
`default_nettype none
module ubx_rx_back import ubx_rx_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  q_head_type head,
   output logic       pop,
   ubx_rsp_if.source  rsp_ch
);

   localparam logic [3:0] PH_HUNT1   = 4'd0;
   localparam logic [3:0] PH_HUNT2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;
   localparam logic [3:0] PH_HOLD    = 4'd9;

   // Parser state.
   logic [3:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] len_lo_ff, len_lo_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  held_len_ff, held_len_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] ck_a_ff, ck_a_in;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // Result register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [BYTE_W-1:0]   msg_class_ff;
   logic [BYTE_W-1:0]   msg_id_ff;
   logic [PLEN_W-1:0]   plen_ff;
   logic                rd_ok_ff;
   logic [BYTE_W-1:0]   mem_q_ff;

   logic [BYTE_W-1:0]   mem [BUF_BYTES];

   cmd_type             cmd;
   logic                out_free;
   logic                fire;
   logic [STATUS_W-1:0] status_in;
   logic                store_en;
   logic                mem_we;
   logic                add_en;
   logic                to_hunt;
   logic                rd_ok_in;
   logic                hold_next;
   logic [BYTE_W-1:0]   sum_a_add;
   logic [BYTE_W-1:0]   sum_b_add;
   logic [15:0]         len16;
   logic                too_long;

   assign cmd      = head.cmd;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = head.valid && out_free;
   assign pop      = fire;

   assign sum_a_add = sum_a_ff + cmd.rx_byte;
   assign sum_b_add = sum_b_ff + sum_a_add;
   assign len16     = {cmd.rx_byte, len_lo_ff};
   assign too_long  = (len16 > 16'(MAX_LEN));

   always_comb begin
      phase_in    = phase_ff;
      len_lo_in   = len_lo_ff;
      left_in     = left_ff;
      held_len_in = held_len_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      ck_a_in     = ck_a_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      fill_in     = fill_ff;
      status_in   = ST_BUSY;
      store_en    = 1'b0;
      add_en      = 1'b0;
      to_hunt     = 1'b0;
      rd_ok_in    = 1'b0;

      case (cmd.kind)
         K_RX: begin
            case (phase_ff)
               PH_HUNT1: begin
                  if (cmd.sync1_hit) begin
                     store_en = 1'b1;
                     phase_in = PH_HUNT2;
                  end else begin
                     to_hunt = 1'b1;
                  end
               end
               PH_HUNT2: begin
                  // A wrong second sync byte is not retried as a first one.
                  if (cmd.sync2_hit) begin
                     store_en = 1'b1;
                     phase_in = PH_CLASS;
                  end else begin
                     to_hunt = 1'b1;
                  end
               end
               PH_CLASS: begin
                  store_en = 1'b1;
                  add_en   = 1'b1;
                  class_in = cmd.rx_byte;
                  phase_in = PH_ID;
               end
               PH_ID: begin
                  store_en = 1'b1;
                  add_en   = 1'b1;
                  id_in    = cmd.rx_byte;
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  store_en  = 1'b1;
                  add_en    = 1'b1;
                  len_lo_in = cmd.rx_byte;
                  phase_in  = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  store_en = 1'b1;
                  add_en   = 1'b1;
                  if (too_long) begin
                     to_hunt   = 1'b1;
                     status_in = ST_TOO_LONG;
                  end else begin
                     held_len_in = LEN_W'(len16);
                     left_in     = LEN_W'(len16);
                     phase_in    = (len16 != '0) ? PH_PAYLOAD : PH_CK_A;
                  end
               end
               PH_PAYLOAD: begin
                  store_en = 1'b1;
                  add_en   = 1'b1;
                  left_in  = (left_ff != '0) ? left_ff - 1'b1 : '0;
                  if (left_ff <= LEN_W'(1)) begin
                     phase_in = PH_CK_A;
                  end
               end
               PH_CK_A: begin
                  store_en = 1'b1;
                  ck_a_in  = cmd.rx_byte;
                  phase_in = PH_CK_B;
               end
               PH_CK_B: begin
                  store_en = 1'b1;
                  if ((ck_a_ff == sum_a_ff) && (cmd.rx_byte == sum_b_ff)) begin
                     phase_in  = PH_HOLD;
                     status_in = ST_OK;
                  end else begin
                     to_hunt   = 1'b1;
                     status_in = ST_BAD_CK;
                  end
               end
               PH_HOLD: begin
                  status_in = ST_REFUSED;
               end
               default: begin
                  to_hunt = 1'b1;
               end
            endcase
         end
         K_DROP: begin
            if (phase_ff == PH_HOLD) begin
               to_hunt   = 1'b1;
               status_in = ST_DROPPED;
            end else begin
               status_in = ST_DROP_REFUSED;
            end
         end
         K_READ: begin
            status_in = ST_READ;
            rd_ok_in  = (32'(cmd.read_index) < 32'(fill_ff)) &&
                        (32'(cmd.read_index) < BUF_BYTES);
         end
         default: begin
            status_in = ST_BUSY;
         end
      endcase

      if (add_en) begin
         sum_a_in = sum_a_add;
         sum_b_in = sum_b_add;
      end
      if (store_en && (fill_ff < FILL_W'(BUF_BYTES))) begin
         fill_in = fill_ff + 1'b1;
      end
      if (to_hunt) begin
         phase_in    = PH_HUNT1;
         left_in     = '0;
         sum_a_in    = '0;
         sum_b_in    = '0;
         fill_in     = '0;
         held_len_in = '0;
      end
   end

   assign mem_we    = store_en && (fill_ff < FILL_W'(BUF_BYTES));
   assign hold_next = (phase_in == PH_HOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         left_ff      <= '0;
         held_len_ff  <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff    <= phase_in;
            left_ff     <= left_in;
            held_len_ff <= held_len_in;
            sum_a_ff    <= sum_a_in;
            sum_b_ff    <= sum_b_in;
            fill_ff     <= fill_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         len_lo_ff    <= len_lo_in;
         ck_a_ff      <= ck_a_in;
         class_ff     <= class_in;
         id_ff        <= id_in;
         status_ff    <= status_in;
         msg_class_ff <= hold_next ? class_in : '0;
         msg_id_ff    <= hold_next ? id_in : '0;
         plen_ff      <= hold_next ? PLEN_W'(held_len_in) : '0;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   // Frame buffer: one write port at the fill position, one registered read port.
   always_ff @(posedge clock) begin
      if (fire && mem_we) begin
         mem[fill_ff[ADDR_W-1:0]] <= cmd.rx_byte;
      end
      if (fire && (cmd.kind == K_READ)) begin
         mem_q_ff <= mem[ADDR_W'(cmd.read_index)];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.msg_class      = msg_class_ff;
   assign rsp_ch.msg_id         = msg_id_ff;
   assign rsp_ch.payload_length = plen_ff;
   assign rsp_ch.read_data      = rd_ok_ff ? mem_q_ff : '0;

   a_hold_fill : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HOLD) |->
         (fill_ff == FILL_W'(held_len_ff) + FILL_W'(FRAME_OVERHEAD)))
      else $error("held frame size does not match its length field");

   a_hunt_empty : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT1) |-> (fill_ff == '0))
      else $error("buffer not empty while hunting for a first sync byte");

   a_ok_holds : assert property (@(posedge clock) disable iff (reset)
      (fire && (status_in == ST_OK)) |=> ((phase_ff == PH_HOLD) && rsp_valid_ff))
      else $error("good frame was not held");

endmodule
`default_nettype wire

[sv/ubx_frame_receiver.sv]
// Top level of the UBX frame receiver: request intake, command queue and parser.
// An accepted item is first registered in the command queue; the parser registers
// its result and read data when it takes the item from the queue head, which waits
// while the response register is full. Throughput: one item per cycle while results
// are taken, as the phase and Fletcher checksum update are combinational.
// Reset (synchronous, active high) empties the queue and returns the parser to the
// first-sync hunt with an empty buffer; buffer bytes beyond the fill read as zero,
// so no clearing pass is needed and items are taken from the first cycle after reset.
`default_nettype none
module ubx_frame_receiver import ubx_rx_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ubx_req_if.sink   req_ch,
   ubx_rsp_if.source rsp_ch
);

   // The front end accepts and classifies each item; the back end executes it.
   // The queue between them lets a stalled response side stop execution while
   // the request side still takes items until the queue fills.
   q_head_type head;
   logic       pop;

   ubx_rx_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   // The back end tracks the frame phase, the running checksum and the frame
   // buffer, and keeps one response item in its output register.
   ubx_rx_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire
